/* hw/rtl/gevc_pkg.sv */
// Package for the graded exponent vector comparator.
// Holds lane geometry, key widths, the key struct and the order codes.
// No dependencies.
package gevc_pkg;

  localparam int MAX_LANES = 8;
  localparam int EXP_BITS  = 8;
  localparam int LANE_STRIDE = 8;
  localparam int VEC_W = MAX_LANES * LANE_STRIDE;
  localparam int CNT_W = 4;

  localparam int DEG_W  = 11;
  localparam int S1_W   = 13;
  localparam int S2_W   = 16;
  localparam int PROD_W = S2_W + DEG_W;
  localparam int SQ_W   = 2 * S1_W;
  localparam int VAR_W  = PROD_W + 1;

  localparam logic [CNT_W-1:0] DIM_RESET = CNT_W'(MAX_LANES);

  localparam logic signed [1:0] ORDER_LESS    = 2'sb11;
  localparam logic signed [1:0] ORDER_EQUAL   = 2'sb00;
  localparam logic signed [1:0] ORDER_GREATER = 2'sb01;

  typedef logic [MAX_LANES-1:0][EXP_BITS-1:0] gevc_lanes_t;

  typedef struct packed {
    logic [DEG_W-1:0] deg;
    logic [S1_W-1:0]  s1;
    logic [S2_W-1:0]  s2;
    gevc_lanes_t      lanes;
  } gevc_key_t;

endpackage

/* hw/rtl/graded_exponent_vector_compare_top.sv */
// Top level of the graded exponent vector comparator.
// Depends on gevc_pkg, gevc_keys and gevc_order.
//
// The block takes one vector pair in every clock cycle and never stalls: busy is always low.
// A transaction accepted at one rising edge is held in the input register. Its order appears
// with done high for exactly one cycle after the next rising edge, and it is taken at the
// edge that ends that cycle. The receiver must take it then. The clock period is set by
// the weighted-sum adders feeding the two degree-by-moment multipliers and the compare
// chain after them.
// The lane count register may be written at any cycle with no transaction in flight.
module graded_exponent_vector_compare_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [gevc_pkg::VEC_W-1:0]    first_exponents,
  input  logic [gevc_pkg::VEC_W-1:0]    second_exponents,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gevc_pkg::CNT_W-1:0]    cfg_data,
  output logic                          done,
  output logic signed [1:0]             order
);
  import gevc_pkg::*;

  logic [CNT_W-1:0]     dimension_count;
  logic                 item_valid;
  logic [VEC_W-1:0]     exps_a;
  logic [VEC_W-1:0]     exps_b;
  logic [MAX_LANES-1:0] lane_mask;
  gevc_key_t            key_a;
  gevc_key_t            key_b;
  logic signed [1:0]    order_next;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      lane_mask[i] = (i == 0) || (CNT_W'(i) < dimension_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension_count <= DIM_RESET;
      item_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dimension_count <= cfg_data;
      end
      item_valid <= start && !busy;
      done <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      exps_a <= first_exponents;
      exps_b <= second_exponents;
    end
    order <= order_next;
  end

  gevc_keys u_keys_a (
    .exps      (exps_a),
    .lane_mask (lane_mask),
    .key       (key_a)
  );

  gevc_keys u_keys_b (
    .exps      (exps_b),
    .lane_mask (lane_mask),
    .key       (key_b)
  );

  gevc_order u_order (
    .key_a      (key_a),
    .key_b      (key_b),
    .order_next (order_next)
  );

`ifndef SYNTHESIS
  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_valid |=> done)
    else $error("registered transaction did not produce a result");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(item_valid))
    else $error("result strobe without a registered transaction");

  a_same_vectors_equal: assert property (@(posedge clk) disable iff (rst)
    item_valid && (exps_a == exps_b) |=> (order == ORDER_EQUAL))
    else $error("identical vectors did not compare as equal");
`endif

endmodule

/* hw/rtl/gevc_keys.sv */
// Key extraction for one exponent vector: masked lanes, degree and weighted sums.
// Depends on gevc_pkg.
module gevc_keys (
  input  logic [gevc_pkg::VEC_W-1:0]     exps,
  input  logic [gevc_pkg::MAX_LANES-1:0] lane_mask,
  output gevc_pkg::gevc_key_t            key
);
  import gevc_pkg::*;

  always_comb begin
    logic [EXP_BITS-1:0] lane;
    logic [DEG_W-1:0] deg;
    logic [S1_W-1:0]  s1;
    logic [S2_W-1:0]  s2;
    gevc_lanes_t      lanes;
    deg = '0;
    s1 = '0;
    s2 = '0;
    for (int i = 0; i < MAX_LANES; i++) begin
      lane = exps[i*LANE_STRIDE +: EXP_BITS] & {EXP_BITS{lane_mask[i]}};
      lanes[i] = lane;
      deg = deg + DEG_W'(lane);
      s1 = s1 + S1_W'(lane) * S1_W'(i);
      s2 = s2 + S2_W'(lane) * S2_W'(i * i);
    end
    key.deg = deg;
    key.s1 = s1;
    key.s2 = s2;
    key.lanes = lanes;
  end

endmodule

/* hw/rtl/gevc_order.sv */
// Ordering logic: degree, then scaled variance, then mean, then lanes from the top down.
// Depends on gevc_pkg.
module gevc_order (
  input  gevc_pkg::gevc_key_t    key_a,
  input  gevc_pkg::gevc_key_t    key_b,
  output logic signed [1:0]      order_next
);
  import gevc_pkg::*;

  logic [PROD_W-1:0]       prod_a, prod_b;
  logic [SQ_W-1:0]         sq_a, sq_b;
  logic signed [VAR_W-1:0] var_a, var_b;
  logic signed [1:0]       lex;

  assign prod_a = PROD_W'(key_a.s2) * PROD_W'(key_a.deg);
  assign prod_b = PROD_W'(key_b.s2) * PROD_W'(key_b.deg);
  assign sq_a = SQ_W'(key_a.s1) * SQ_W'(key_a.s1);
  assign sq_b = SQ_W'(key_b.s1) * SQ_W'(key_b.s1);
  assign var_a = $signed({1'b0, prod_a}) - $signed(VAR_W'(sq_a));
  assign var_b = $signed({1'b0, prod_b}) - $signed(VAR_W'(sq_b));

  // The highest differing lane decides, so later lanes overwrite earlier ones.
  always_comb begin
    lex = ORDER_EQUAL;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (key_a.lanes[i] < key_b.lanes[i]) begin
        lex = ORDER_LESS;
      end else if (key_a.lanes[i] > key_b.lanes[i]) begin
        lex = ORDER_GREATER;
      end
    end
  end

  always_comb begin
    if (key_a.deg != key_b.deg) begin
      order_next = (key_a.deg < key_b.deg) ? ORDER_LESS : ORDER_GREATER;
    end else if (var_a != var_b) begin
      order_next = (var_a < var_b) ? ORDER_LESS : ORDER_GREATER;
    end else if (key_a.s1 != key_b.s1) begin
      order_next = (key_a.s1 < key_b.s1) ? ORDER_LESS : ORDER_GREATER;
    end else begin
      order_next = lex;
    end
  end

endmodule
